>>> design/gog_pkg.sv
// Shared types and constants for the glyph outline and gradient block.
package gog_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 8;
    localparam int ROW_W      = 10;
    localparam int COL_MAX_W  = 12;
    localparam int DIVIDEND_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

    localparam logic [CFG_W-1:0] CFG_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_W-1:0] CFG_HEIGHT_RESET = 11'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT     = 11'd1024;

    localparam logic [PIX_W-1:0] INK_THRESHOLD = 8'd2;
    localparam logic [PIX_W-1:0] OUTLINE_PIX   = 8'd1;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_RAW
    } gog_back_state_t;

    // One classified input pixel, as queued between front and back.
    typedef struct packed {
        logic [PIX_W-1:0]     pixel;
        logic [COL_MAX_W-1:0] col;
        logic [ROW_W-1:0]     row_prev;
        logic                 first_row;
        logic                 last_row;
        logic                 last_col;
        logic                 row_start;
        logic                 interior;
    } gog_item_t;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pixel;
    } gog_result_t;

endpackage

>>> design/gog_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/gog_fifo.sv
// Small synchronous FIFO, power-of-two depth, head visible without a pop.
module gog_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/gog_front.sv
// Front end: takes pixel beats, tracks row and column, classifies each pixel.
module gog_front
    import gog_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  logic [CFG_W-1:0]    image_width,
    input  logic [CFG_W-1:0]    image_height,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [PIX_W-1:0]    in_pixel,
    input  logic                q_full,
    output logic                q_push,
    output gog_item_t           q_item,
    output logic [ROW_W-1:0]    shade_divisor
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WCW   = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WCW > CFG_W) ? WCW : CFG_W;

    logic [AW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0] width_ext, width_eff;
    logic [CFG_W-1:0] height_eff;
    logic             last_col, last_row;

    // 0 acts as 1, oversize values clamp to the store depth / row limit
    always_comb
    begin
        width_ext = CMP_W'(image_width);
        if (width_ext == '0)
        begin
            width_eff = CMP_W'(1);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            width_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end

        if (image_height == '0)
        begin
            height_eff = CFG_W'(1);
        end
        else if (image_height > HEIGHT_LIMIT)
        begin
            height_eff = HEIGHT_LIMIT;
        end
        else
        begin
            height_eff = image_height;
        end
    end

    assign last_col      = (CMP_W'(col_reg) + CMP_W'(1) == width_eff);
    assign last_row      = (CFG_W'(row_reg) + CFG_W'(1) == height_eff);
    assign shade_divisor = ROW_W'(height_eff - CFG_W'(1));

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.pixel     = in_pixel;
        q_item.col       = COL_MAX_W'(col_reg);
        q_item.row_prev  = row_reg - ROW_W'(1);
        q_item.first_row = (row_reg == '0);
        q_item.last_row  = last_row;
        q_item.last_col  = last_col;
        q_item.row_start = (row_reg != '0) && (col_reg == '0);
        q_item.interior  = (row_reg > ROW_W'(1)) && (col_reg != '0) && !last_col;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (q_push)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> design/gog_div.sv
// Row shade unit: 254*row/divisor + 1, restoring division, one bit a cycle.
module gog_div
    import gog_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             start,
    input  logic [ROW_W-1:0] row_prev,
    input  logic [ROW_W-1:0] divisor,
    output logic             busy,
    output logic [PIX_W-1:0] shade
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [ROW_W-1:0]      rem_reg, rem_next;
    logic [ROW_W-1:0]      div_reg, div_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PIX_W-1:0]      shade_reg, shade_next;
    logic [ROW_W:0]        trial, diff;
    logic                  ge;
    logic [DIVIDEND_W-1:0] dividend;

    // 254*r as 256*r - 2*r
    assign dividend = {row_prev, 8'b0} - {7'b0, row_prev, 1'b0};

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    assign busy  = (cnt_reg != '0);
    assign shade = shade_reg;

    always_comb
    begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        shade_next = shade_reg;
        if (clear)
        begin
            cnt_next   = '0;
            shade_next = '0;
        end
        else if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
            cnt_next = CNT_W'(DIVIDEND_W);
        end
        else if (busy)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[ROW_W-1:0] : trial[ROW_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                shade_next = quo_next[PIX_W-1:0] + PIX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            shade_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            shade_reg <= shade_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

>>> design/gog_back.sv
// Back end: row stores, outline and shade rule, result beats.
module gog_back
    import gog_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             restart,
    input  logic             q_valid,
    input  gog_item_t        q_item,
    output logic             q_pop,
    input  logic             div_busy,
    input  logic [PIX_W-1:0] row_shade,
    output logic             div_start,
    input  logic             out_full,
    output logic             out_push,
    output gog_result_t      out_res
);

    localparam int AW = $clog2(MAX_WIDTH);

    gog_back_state_t  state_reg, state_next;
    logic [PIX_W-1:0] left_reg, left_next;
    logic [PIX_W-1:0] raw_pix_reg, raw_pix_next;
    logic             raw_last_reg, raw_last_next;

    logic [AW-1:0]    addr_cur, addr_right;
    logic [PIX_W-1:0] raw_cur, raw_right, done_up;
    logic [PIX_W-1:0] proc_pix, done_wdata;
    logic             we;

    assign addr_cur   = q_item.col[AW-1:0];
    assign addr_right = addr_cur + AW'(1);

    // two copies of the raw row: one read at x, one at x+1
    gog_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_raw_cur (
        .clk   (clk),
        .we    (we),
        .waddr (addr_cur),
        .wdata (q_item.pixel),
        .raddr (addr_cur),
        .rdata (raw_cur)
    );

    gog_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_raw_right (
        .clk   (clk),
        .we    (we),
        .waddr (addr_cur),
        .wdata (q_item.pixel),
        .raddr (addr_right),
        .rdata (raw_right)
    );

    gog_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_done (
        .clk   (clk),
        .we    (we),
        .waddr (addr_cur),
        .wdata (done_wdata),
        .raddr (addr_cur),
        .rdata (done_up)
    );

    always_comb
    begin
        proc_pix = raw_cur;
        if (q_item.interior)
        begin
            if (raw_cur > INK_THRESHOLD)
            begin
                proc_pix = row_shade;
            end
            else if ((left_reg > INK_THRESHOLD) || (raw_right > INK_THRESHOLD) ||
                     (done_up > INK_THRESHOLD) || (q_item.pixel > INK_THRESHOLD))
            begin
                proc_pix = OUTLINE_PIX;
            end
        end
    end

    assign done_wdata = q_item.first_row ? q_item.pixel : proc_pix;

    always_comb
    begin
        state_next    = state_reg;
        left_next     = left_reg;
        raw_pix_next  = raw_pix_reg;
        raw_last_next = raw_last_reg;
        q_pop         = 1'b0;
        we            = 1'b0;
        div_start     = 1'b0;
        out_push      = 1'b0;
        out_res.last  = 1'b0;
        out_res.pixel = proc_pix;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!out_full && !(q_item.interior && div_busy))
                begin
                    q_pop      = 1'b1;
                    we         = 1'b1;
                    div_start  = q_item.row_start;
                    state_next = BK_IDLE;
                    if (!q_item.first_row)
                    begin
                        left_next = proc_pix;
                        out_push  = 1'b1;
                        if (q_item.last_row)
                        begin
                            raw_pix_next  = q_item.pixel;
                            raw_last_next = q_item.last_col;
                            state_next    = BK_RAW;
                        end
                    end
                    else if (q_item.last_row)
                    begin
                        out_push      = 1'b1;
                        out_res.last  = q_item.last_col;
                        out_res.pixel = q_item.pixel;
                    end
                end
            end
            BK_RAW:
            begin
                out_res.last  = raw_last_reg;
                out_res.pixel = raw_pix_reg;
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (restart)
        begin
            left_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_pix_reg  <= raw_pix_next;
        raw_last_reg <= raw_last_next;
    end

endmodule

>>> design/glyph_outline_gradient_top.sv
// Top level of the glyph outline and vertical gradient block.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata[7:0] raw pixel
//  m_*      out  m_tvalid/m_tready    m_tdata[7:0] pixel, m_tlast end of image
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data[10:0]
//
// In the back end each pixel is read from the row stores, then updated and
// written; a last-row pixel below row 0 then sends a second beat from BK_RAW.
// The shade divider starts at column 0 of a row, and the first interior pixel
// of that row may stall until the divider is no longer busy.
// A 4-beat queue parts front and back, a 2-beat queue drives m_*; either
// side may stall without loss.
// Reset is asynchronous, active low; counters restart on a width or height write.
module glyph_outline_gradient_top
    import gog_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,      // [7:0] pixel_in
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,      // [7:0] pixel_out
    output logic                 m_tlast,      // end_of_image
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ITEM_W = $bits(gog_item_t);
    localparam int RES_W  = $bits(gog_result_t);

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic             restart;

    logic              q_push, q_full, q_pop, q_empty;
    gog_item_t         q_in, q_head;
    logic [ITEM_W-1:0] q_head_bits;
    logic [ROW_W-1:0]  shade_divisor;

    logic              div_start, div_busy;
    logic [PIX_W-1:0]  row_shade;

    logic              out_push, out_full, out_empty;
    gog_result_t       out_res, out_head;
    logic [RES_W-1:0]  out_head_bits;

    // configuration: always ready, known index restarts the image
    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid &&
                       ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && (cfg_index == CFG_IMAGE_WIDTH))
        begin
            width_next = cfg_data;
        end
        if (cfg_valid && (cfg_index == CFG_IMAGE_HEIGHT))
        begin
            height_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_WIDTH_RESET;
            height_reg <= CFG_HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    gog_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (restart),
        .image_width   (width_reg),
        .image_height  (height_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_pixel      (s_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in),
        .shade_divisor (shade_divisor)
    );

    // classified pixels, front to back
    gog_fifo #(.WIDTH(ITEM_W), .DEPTH(4)) u_item_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head_bits),
        .empty     (q_empty)
    );

    assign q_head = gog_item_t'(q_head_bits);

    gog_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (restart),
        .start    (div_start),
        .row_prev (q_head.row_prev),
        .divisor  (shade_divisor),
        .busy     (div_busy),
        .shade    (row_shade)
    );

    gog_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .q_valid   (!q_empty),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .div_busy  (div_busy),
        .row_shade (row_shade),
        .div_start (div_start),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_res   (out_res)
    );

    // result beats, decoupled from m_tready
    gog_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_res),
        .full      (out_full),
        .pop       (m_tvalid && m_tready),
        .pop_data  (out_head_bits),
        .empty     (out_empty)
    );

    assign out_head = gog_result_t'(out_head_bits);
    assign m_tvalid = !out_empty;
    assign m_tdata  = out_head.pixel;
    assign m_tlast  = out_head.last;

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into full output queue");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end consumed from empty item queue");

    a_shade_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.interior) |-> !div_busy)
        else $error("interior pixel processed before row shade was ready");
`endif

endmodule
